>>> rtl/hmq_pkg.sv
// ----------------------------------------------------------------------------
// hmq_pkg: shared types and codes of the indexed min-heap queue
// Entry layout, action and status codes, result word and default sizes.
// ----------------------------------------------------------------------------
package hmq_pkg;

   localparam int CAPACITY_DEF     = 1024;
   localparam int VERTEX_COUNT_DEF = 4096;

   localparam int KEY_W   = 32;
   localparam int VTX_W   = 12;
   localparam int COORD_W = 16;
   localparam int ACT_W   = 2;
   localparam int STAT_W  = 3;

   localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_EXTRACT  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DECREASE = 2'd2;
   localparam logic [ACT_W-1:0] ACT_QUERY    = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL        = 3'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY       = 3'd2;
   localparam logic [STAT_W-1:0] ST_ABSENT      = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_SMALLER = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VTX_W-1:0]   vertex;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [STAT_W-1:0] status;
      entry_type         entry;
      logic              present;
      logic              empty;
   } result_type;

endpackage

>>> rtl/hmq_ram.sv
// ----------------------------------------------------------------------------
// hmq_ram: simple dual-port memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                    wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                    rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> rtl/hmq_seq.sv
// ----------------------------------------------------------------------------
// hmq_seq: heap sequencer
// Runs insert, extract, decrease and query over the heap and position
// memories with one shared key comparator, working one heap level at a time.
// ----------------------------------------------------------------------------
module hmq_seq #(
   parameter int CAPACITY     = hmq_pkg::CAPACITY_DEF,
   parameter int VERTEX_COUNT = hmq_pkg::VERTEX_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [hmq_pkg::ACT_W-1:0] in_action,
   input  hmq_pkg::entry_type        in_entry,
   output logic                      done_valid,
   input  logic                      done_ready,
   output hmq_pkg::result_type       result
);

   localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = PW + 2;
   localparam int VW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam int XW = (VW > hmq_pkg::VTX_W) ? VW : hmq_pkg::VTX_W;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_PQ_CHK = 4'd2;
   localparam logic [3:0] S_DK_CHK = 4'd3;
   localparam logic [3:0] S_EX_OUT = 4'd4;
   localparam logic [3:0] S_EX_LST = 4'd5;
   localparam logic [3:0] S_EX_CLR = 4'd6;
   localparam logic [3:0] S_SD_L   = 4'd7;
   localparam logic [3:0] S_SD_LC  = 4'd8;
   localparam logic [3:0] S_SD_RC  = 4'd9;
   localparam logic [3:0] S_SD_DEC = 4'd10;
   localparam logic [3:0] S_SD_END = 4'd11;
   localparam logic [3:0] S_SU_P   = 4'd12;
   localparam logic [3:0] S_SU_C   = 4'd13;
   localparam logic [3:0] S_SU_END = 4'd14;
   localparam logic [3:0] S_DONE   = 4'd15;

   function automatic logic [VW-1:0] vidx(input logic [hmq_pkg::VTX_W-1:0] v);
      logic [XW-1:0] t;
      t = XW'(v);
      return t[VW-1:0];
   endfunction

   logic [3:0]                 state_ff, state_in;
   logic [VW-1:0]              clr_ff, clr_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [hmq_pkg::ACT_W-1:0]  act_ff, act_in;
   hmq_pkg::entry_type         cur_ff, cur_in;
   hmq_pkg::entry_type         best_ff, best_in;
   hmq_pkg::entry_type         out_ff, out_in;
   logic [PW-1:0]              best_idx_ff, best_idx_in;
   logic                       have_ff, have_in;
   logic [PW-1:0]              i_ff, i_in;
   logic [PW-1:0]              par_ff, par_in;
   logic                       moved_ff, moved_in;
   logic                       setpos_ff, setpos_in;
   logic [hmq_pkg::STAT_W-1:0] status_ff, status_in;
   logic                       present_ff, present_in;

   logic                       heap_we;
   logic [PW-1:0]              heap_waddr, heap_raddr;
   hmq_pkg::entry_type         heap_wdata, heap_rdata;
   logic                       pos_we;
   logic [VW-1:0]              pos_waddr, pos_raddr;
   logic [PW:0]                pos_wdata, pos_rdata;

   logic [hmq_pkg::KEY_W-1:0]  cmp_a, cmp_b;
   logic                       cmp_lt;
   logic [LW-1:0]              l_w, r_w, cnt_w;
   logic                       v_ok;

   hmq_ram #(.WIDTH(hmq_pkg::ENTRY_W), .DEPTH(CAPACITY)) u_heap (
      .clock (clock),
      .we    (heap_we),
      .waddr (heap_waddr),
      .wdata (heap_wdata),
      .raddr (heap_raddr),
      .rdata (heap_rdata)
   );

   hmq_ram #(.WIDTH(PW + 1), .DEPTH(VERTEX_COUNT)) u_pos (
      .clock (clock),
      .we    (pos_we),
      .waddr (pos_waddr),
      .wdata (pos_wdata),
      .raddr (pos_raddr),
      .rdata (pos_rdata)
   );

   assign l_w   = {1'b0, i_ff, 1'b1};
   assign r_w   = l_w + LW'(1);
   assign cnt_w = LW'(count_ff);
   assign v_ok  = 32'(in_entry.vertex) < 32'(VERTEX_COUNT);

   always_comb begin
      cmp_a = heap_rdata.key;
      cmp_b = cur_ff.key;
      case (state_ff)
         S_SD_RC: begin
            cmp_b = have_ff ? best_ff.key : cur_ff.key;
         end
         S_SU_C: begin
            cmp_a = cur_ff.key;
            cmp_b = heap_rdata.key;
         end
         S_DK_CHK: begin
            cmp_a = cur_ff.key;
            cmp_b = heap_rdata.key;
         end
         default: begin
         end
      endcase
   end

   assign cmp_lt = cmp_a < cmp_b;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      count_in    = count_ff;
      act_in      = act_ff;
      cur_in      = cur_ff;
      best_in     = best_ff;
      out_in      = out_ff;
      best_idx_in = best_idx_ff;
      have_in     = have_ff;
      i_in        = i_ff;
      par_in      = par_ff;
      moved_in    = moved_ff;
      setpos_in   = setpos_ff;
      status_in   = status_ff;
      present_in  = present_ff;
      heap_we     = 1'b0;
      heap_waddr  = i_ff;
      heap_wdata  = cur_ff;
      heap_raddr  = '0;
      pos_we      = 1'b0;
      pos_waddr   = vidx(cur_ff.vertex);
      pos_wdata   = {1'b1, i_ff};
      pos_raddr   = vidx(in_entry.vertex);
      in_ready    = 1'b0;
      done_valid  = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            pos_we    = 1'b1;
            pos_waddr = clr_ff;
            pos_wdata = '0;
            clr_in    = clr_ff + VW'(1);
            if (clr_ff == VW'(VERTEX_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               act_in     = in_action;
               cur_in     = in_entry;
               out_in     = '0;
               present_in = 1'b0;
               status_in  = hmq_pkg::ST_OK;
               moved_in   = 1'b0;
               setpos_in  = 1'b0;
               case (in_action)
                  hmq_pkg::ACT_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        status_in = hmq_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end else if (!v_ok) begin
                        status_in = hmq_pkg::ST_ABSENT;
                        state_in  = S_DONE;
                     end else begin
                        i_in      = PW'(count_ff);
                        count_in  = count_ff + CW'(1);
                        setpos_in = 1'b1;
                        state_in  = S_SU_P;
                     end
                  end
                  hmq_pkg::ACT_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = hmq_pkg::ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_EX_OUT;
                     end
                  end
                  default: begin
                     if (!v_ok) begin
                        if (in_action == hmq_pkg::ACT_DECREASE) begin
                           status_in = hmq_pkg::ST_ABSENT;
                        end
                        state_in = S_DONE;
                     end else begin
                        state_in = S_PQ_CHK;
                     end
                  end
               endcase
            end
         end
         S_PQ_CHK: begin
            if (pos_rdata[PW] && ((CW + 1)'(pos_rdata[PW-1:0]) < (CW + 1)'(count_ff))) begin
               if (act_ff == hmq_pkg::ACT_QUERY) begin
                  present_in = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  i_in       = pos_rdata[PW-1:0];
                  heap_raddr = pos_rdata[PW-1:0];
                  state_in   = S_DK_CHK;
               end
            end else begin
               if (act_ff == hmq_pkg::ACT_DECREASE) begin
                  status_in = hmq_pkg::ST_ABSENT;
               end
               state_in = S_DONE;
            end
         end
         S_DK_CHK: begin
            if (cmp_lt) begin
               cur_in     = heap_rdata;
               cur_in.key = cur_ff.key;
               state_in   = S_SU_P;
            end else begin
               status_in = hmq_pkg::ST_NOT_SMALLER;
               state_in  = S_DONE;
            end
         end
         S_EX_OUT: begin
            out_in = heap_rdata;
            if (count_ff == CW'(1)) begin
               count_in  = '0;
               pos_we    = 1'b1;
               pos_waddr = vidx(heap_rdata.vertex);
               pos_wdata = '0;
               state_in  = S_DONE;
            end else begin
               heap_raddr = PW'(count_ff - CW'(1));
               state_in   = S_EX_LST;
            end
         end
         S_EX_LST: begin
            cur_in    = heap_rdata;
            count_in  = count_ff - CW'(1);
            pos_we    = 1'b1;
            pos_waddr = vidx(heap_rdata.vertex);
            pos_wdata = '0;
            pos_wdata[PW] = 1'b1;
            state_in  = S_EX_CLR;
         end
         S_EX_CLR: begin
            pos_we    = 1'b1;
            pos_waddr = vidx(out_ff.vertex);
            pos_wdata = '0;
            i_in      = '0;
            state_in  = S_SD_L;
         end
         S_SD_L: begin
            have_in = 1'b0;
            if (l_w >= cnt_w) begin
               state_in = S_SD_END;
            end else begin
               heap_raddr = l_w[PW-1:0];
               state_in   = S_SD_LC;
            end
         end
         S_SD_LC: begin
            if (cmp_lt) begin
               best_in     = heap_rdata;
               best_idx_in = l_w[PW-1:0];
               have_in     = 1'b1;
            end
            if (r_w < cnt_w) begin
               heap_raddr = r_w[PW-1:0];
               state_in   = S_SD_RC;
            end else begin
               state_in = S_SD_DEC;
            end
         end
         S_SD_RC: begin
            if (cmp_lt) begin
               best_in     = heap_rdata;
               best_idx_in = r_w[PW-1:0];
               have_in     = 1'b1;
            end
            state_in = S_SD_DEC;
         end
         S_SD_DEC: begin
            if (have_ff) begin
               heap_we    = 1'b1;
               heap_wdata = best_ff;
               pos_we     = 1'b1;
               pos_waddr  = vidx(best_ff.vertex);
               i_in       = best_idx_ff;
               moved_in   = 1'b1;
               state_in   = S_SD_L;
            end else begin
               state_in = S_SD_END;
            end
         end
         S_SD_END: begin
            heap_we  = 1'b1;
            pos_we   = moved_ff;
            state_in = S_DONE;
         end
         S_SU_P: begin
            if (i_ff == '0) begin
               state_in = S_SU_END;
            end else begin
               par_in     = PW'((i_ff - PW'(1)) >> 1);
               heap_raddr = PW'((i_ff - PW'(1)) >> 1);
               state_in   = S_SU_C;
            end
         end
         S_SU_C: begin
            if (cmp_lt) begin
               heap_we    = 1'b1;
               heap_wdata = heap_rdata;
               pos_we     = 1'b1;
               pos_waddr  = vidx(heap_rdata.vertex);
               i_in       = par_ff;
               moved_in   = 1'b1;
               state_in   = S_SU_P;
            end else begin
               state_in = S_SU_END;
            end
         end
         S_SU_END: begin
            heap_we  = 1'b1;
            pos_we   = moved_ff || setpos_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result.status  = status_ff;
   assign result.entry   = out_ff;
   assign result.present = present_ff;
   assign result.empty   = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
      act_ff      <= act_in;
      cur_ff      <= cur_in;
      best_ff     <= best_in;
      out_ff      <= out_in;
      best_idx_ff <= best_idx_in;
      have_ff     <= have_in;
      i_ff        <= i_in;
      par_ff      <= par_in;
      moved_ff    <= moved_in;
      setpos_ff   <= setpos_in;
      status_ff   <= status_in;
      present_ff  <= present_in;
   end

`ifndef NO_ASSERTIONS
   a_heap_write_live: assert property (@(posedge clock) disable iff (reset)
      heap_we |-> ((CW + 1)'(heap_waddr) < (CW + 1)'(count_ff)))
      else $error("heap write beyond live entries");

   a_pos_slot_live: assert property (@(posedge clock) disable iff (reset)
      (pos_we && pos_wdata[PW]) |-> ((CW + 1)'(pos_wdata[PW-1:0]) < (CW + 1)'(count_ff)))
      else $error("position map points beyond live entries");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (state_ff != S_IDLE))
      else $error("accepted word did not start work");

   a_done_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      done_valid |-> !in_ready)
      else $error("result offered while accepting");
`endif

endmodule

>>> rtl/indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue: indexed binary min-heap with decrease-key
// Priority queue over vertices with a position map for shortest-path search.
//
//   channel | direction | tdata                               | tuser
//   req     | in        | vertex, row, col, key               | action
//   rsp     | out       | vertex, row, col, key, present, empty | status
//
// After reset the position map is cleared, one entry at a time; no word is taken meanwhile.
// An insert climbs level by level; a decrease checks the stored key and climbs;
// an extract moves the last entry to the root and descends level by level; a query
// reads only the position map. The next word is taken the cycle after the result moves on.
// The heap memory's one read port and the shared key compare set the pace.
// A finished result waits in the output register while the next word is taken;
// with that register full and rsp_tready low, hold the result in the sequencer.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue #(
   parameter int CAPACITY     = hmq_pkg::CAPACITY_DEF,
   parameter int VERTEX_COUNT = hmq_pkg::VERTEX_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // vertex, row, col, key, pad
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // out_vertex, out_row, out_col, out_key, present, empty_res, pad
   output logic [2:0]  rsp_tuser    // status
);

   hmq_pkg::entry_type  in_entry;
   hmq_pkg::result_type result;
   hmq_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                done_valid, done_ready;

   assign in_entry.vertex = req_tdata[11:0];
   assign in_entry.row    = req_tdata[27:12];
   assign in_entry.col    = req_tdata[43:28];
   assign in_entry.key    = req_tdata[75:44];

   hmq_seq #(.CAPACITY(CAPACITY), .VERTEX_COUNT(VERTEX_COUNT)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_action  (req_tuser),
      .in_entry   (in_entry),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .result     (result)
   );

   assign done_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_valid && done_ready) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {2'b00, rsp_ff.empty, rsp_ff.present, rsp_ff.entry.key,
                        rsp_ff.entry.col, rsp_ff.entry.row, rsp_ff.entry.vertex};

endmodule

>>> tb/tb_indexed_min_heap_queue_checker.sv
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_queue_checker: result checker of the min-heap queue
// Watches both channels, keeps its own copy of the heap and the position map,
// works out each result from every accepted request word, and compares every
// response word with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_queue_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          fail_count,
   output int          pending,
   output int          extract_count,
   output int          full_count
);

   localparam int CAP = hmq_pkg::CAPACITY_DEF;
   localparam int VCNT = hmq_pkg::VERTEX_COUNT_DEF;

   logic [hmq_pkg::KEY_W-1:0]   heap_key [CAP];
   logic [hmq_pkg::VTX_W-1:0]   heap_vtx [CAP];
   logic [hmq_pkg::COORD_W-1:0] heap_row [CAP];
   logic [hmq_pkg::COORD_W-1:0] heap_col [CAP];
   int                          vtx_slot [VCNT];
   bit                          vtx_mapped [VCNT];
   int                          live_count;
   hmq_pkg::result_type         expected_results[$];

   task automatic swap_slots(input int a, input int b);
      logic [hmq_pkg::KEY_W-1:0]   k;
      logic [hmq_pkg::VTX_W-1:0]   v;
      logic [hmq_pkg::COORD_W-1:0] r;
      logic [hmq_pkg::COORD_W-1:0] c;
      k = heap_key[a]; heap_key[a] = heap_key[b]; heap_key[b] = k;
      v = heap_vtx[a]; heap_vtx[a] = heap_vtx[b]; heap_vtx[b] = v;
      r = heap_row[a]; heap_row[a] = heap_row[b]; heap_row[b] = r;
      c = heap_col[a]; heap_col[a] = heap_col[b]; heap_col[b] = c;
      vtx_slot[heap_vtx[a]] = a; vtx_mapped[heap_vtx[a]] = 1'b1;
      vtx_slot[heap_vtx[b]] = b; vtx_mapped[heap_vtx[b]] = 1'b1;
   endtask

   task automatic climb(input int i);
      int p;
      while (i != 0) begin
         p = (i - 1) / 2;
         if (!(heap_key[p] > heap_key[i])) break;
         swap_slots(i, p);
         i = p;
      end
   endtask

   task automatic descend(input int i);
      int l;
      int r;
      int s;
      forever begin
         l = 2 * i + 1;
         r = 2 * i + 2;
         s = i;
         if (l < live_count && heap_key[l] < heap_key[s]) s = l;
         if (r < live_count && heap_key[r] < heap_key[s]) s = r;
         if (s == i) break;
         swap_slots(i, s);
         i = s;
      end
   endtask

   function automatic bit vertex_held(input logic [hmq_pkg::VTX_W-1:0] v);
      return vtx_mapped[v] && vtx_slot[v] < live_count;
   endfunction

   task automatic apply_request(input logic [1:0] act, input logic [79:0] d);
      logic [hmq_pkg::VTX_W-1:0]   v;
      logic [hmq_pkg::KEY_W-1:0]   k;
      hmq_pkg::result_type         res;
      int                          i;
      v = d[11:0];
      k = d[75:44];
      res = '0;
      res.status = hmq_pkg::ST_OK;
      case (act)
         hmq_pkg::ACT_INSERT: begin
            if (live_count >= CAP) begin
               res.status = hmq_pkg::ST_FULL;
               full_count++;
            end else begin
               i = live_count;
               live_count++;
               heap_key[i] = k;
               heap_vtx[i] = v;
               heap_row[i] = d[27:12];
               heap_col[i] = d[43:28];
               vtx_slot[v] = i; vtx_mapped[v] = 1'b1;
               climb(i);
            end
         end
         hmq_pkg::ACT_EXTRACT: begin
            if (live_count == 0) begin
               res.status = hmq_pkg::ST_EMPTY;
            end else begin
               extract_count++;
               res.entry.vertex = heap_vtx[0];
               res.entry.row = heap_row[0];
               res.entry.col = heap_col[0];
               res.entry.key = heap_key[0];
               i = live_count - 1;
               if (i == 0) begin
                  live_count = 0;
                  vtx_mapped[res.entry.vertex] = 1'b0;
               end else begin
                  heap_key[0] = heap_key[i];
                  heap_vtx[0] = heap_vtx[i];
                  heap_row[0] = heap_row[i];
                  heap_col[0] = heap_col[i];
                  vtx_slot[heap_vtx[0]] = 0; vtx_mapped[heap_vtx[0]] = 1'b1;
                  vtx_mapped[res.entry.vertex] = 1'b0;
                  live_count = i;
                  descend(0);
               end
            end
         end
         hmq_pkg::ACT_DECREASE: begin
            if (!vertex_held(v)) begin
               res.status = hmq_pkg::ST_ABSENT;
            end else begin
               i = vtx_slot[v];
               if (heap_key[i] <= k) begin
                  res.status = hmq_pkg::ST_NOT_SMALLER;
               end else begin
                  heap_key[i] = k;
                  climb(i);
               end
            end
         end
         default: res.present = vertex_held(v);
      endcase
      res.empty = (live_count == 0);
      expected_results.push_back(res);
   endtask

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: mismatch in %s, expected %0h, actual %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      hmq_pkg::result_type exp_r;
      if (reset) begin
         live_count = 0;
         for (int n = 0; n < VCNT; n++) vtx_mapped[n] = 1'b0;
         expected_results.delete();
         fail_count = 0;
         extract_count = 0;
         full_count = 0;
      end else begin
         if (req_tvalid && req_tready) apply_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual %0h/%0h",
                        $time, rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               exp_r = expected_results.pop_front();
               compare_field("status", exp_r.status, rsp_tuser);
               compare_field("vertex", exp_r.entry.vertex, rsp_tdata[11:0]);
               compare_field("row", exp_r.entry.row, rsp_tdata[27:12]);
               compare_field("col", exp_r.entry.col, rsp_tdata[43:28]);
               compare_field("key", exp_r.entry.key, rsp_tdata[75:44]);
               compare_field("present", exp_r.present, rsp_tdata[76]);
               compare_field("empty", exp_r.empty, rsp_tdata[77]);
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

>>> tb/tb_indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_queue: testbench of the indexed min-heap queue
// Drives directed and random request words in bursts with random gaps,
// stalls the response side on its own pattern, fills the heap past capacity
// and then runs an extract-heavy mix; the checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_queue;

   localparam int LIMIT = 3000000;
   localparam int VTX_BITS = hmq_pkg::VTX_W;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // vertex, row, col, key, pad
   logic [1:0]  req_tuser = '0;   // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // out_vertex, out_row, out_col, out_key, present, empty_res, pad
   logic [2:0]  rsp_tuser;        // status
   int          fail_count;
   int          pending;
   int          extract_count;
   int          full_count;
   int          cycles = 0;
   int          burst_left = 0;
   int          words_sent = 0;
   int          stall_mode = 0;

   indexed_min_heap_queue u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   tb_indexed_min_heap_queue_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending(pending),
      .extract_count(extract_count), .full_count(full_count)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_indexed_min_heap_queue failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if ($urandom_range(63) == 0) stall_mode <= $urandom_range(3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(3) != 0);
         2: rsp_tready <= ($urandom_range(3) == 0);
         default: rsp_tready <= cycles[3];
      endcase
   end

   task automatic send_word(input logic [hmq_pkg::ACT_W-1:0] act,
                            input logic [hmq_pkg::VTX_W-1:0] v,
                            input logic [15:0] r, input logic [15:0] c,
                            input logic [31:0] k);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {4'd0, k, c, r, v};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom >> $urandom_range(12);
      endcase
   endfunction

   function automatic logic [hmq_pkg::VTX_W-1:0] pick_vertex();
      if ($urandom_range(3) != 0) return VTX_BITS'($urandom_range(127));
      return VTX_BITS'($urandom_range(4095));
   endfunction

   task automatic random_mix(input int n, input int ins_w, input int ext_w, input int dec_w);
      int sel;
      logic [hmq_pkg::ACT_W-1:0] act;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < ins_w) act = hmq_pkg::ACT_INSERT;
         else if (sel < ins_w + ext_w) act = hmq_pkg::ACT_EXTRACT;
         else if (sel < ins_w + ext_w + dec_w) act = hmq_pkg::ACT_DECREASE;
         else act = hmq_pkg::ACT_QUERY;
         send_word(act, pick_vertex(), 16'($urandom), 16'($urandom), pick_key());
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, extremes, duplicates, ties
      send_word(hmq_pkg::ACT_EXTRACT, 12'd0, 16'd0, 16'd0, 32'd0);
      send_word(hmq_pkg::ACT_DECREASE, 12'd7, 16'd0, 16'd0, 32'd1);
      send_word(hmq_pkg::ACT_QUERY, 12'd4095, 16'd0, 16'd0, 32'd0);
      send_word(hmq_pkg::ACT_INSERT, 12'd4095, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(hmq_pkg::ACT_INSERT, 12'd0, 16'd0, 16'd0, 32'd0);
      send_word(hmq_pkg::ACT_INSERT, 12'd5, 16'h1234, 16'hABCD, 32'h0000_5000);
      send_word(hmq_pkg::ACT_INSERT, 12'd5, 16'h4321, 16'hDCBA, 32'h0000_5000);
      send_word(hmq_pkg::ACT_INSERT, 12'd9, 16'h0001, 16'h8000, 32'h0000_5000);
      send_word(hmq_pkg::ACT_QUERY, 12'd4095, 16'd0, 16'd0, 32'd0);
      send_word(hmq_pkg::ACT_QUERY, 12'd6, 16'd0, 16'd0, 32'd0);
      send_word(hmq_pkg::ACT_DECREASE, 12'd9, 16'd0, 16'd0, 32'h0000_5000);
      send_word(hmq_pkg::ACT_DECREASE, 12'd9, 16'd0, 16'd0, 32'h0000_6000);
      send_word(hmq_pkg::ACT_DECREASE, 12'd4095, 16'd0, 16'd0, 32'd1);
      send_word(hmq_pkg::ACT_DECREASE, 12'd4095, 16'd0, 16'd0, 32'd0);
      for (int i = 0; i < 7; i++) begin
         send_word(hmq_pkg::ACT_EXTRACT, 12'd0, 16'd0, 16'd0, 32'd0);
      end
      send_word(hmq_pkg::ACT_INSERT, 12'd33, 16'd1, 16'd2, 32'd3);
      send_word(hmq_pkg::ACT_INSERT, 12'd33, 16'd4, 16'd5, 32'd3);
      send_word(hmq_pkg::ACT_EXTRACT, 12'd0, 16'd0, 16'd0, 32'd0);
      send_word(hmq_pkg::ACT_QUERY, 12'd33, 16'd0, 16'd0, 32'd0);
      send_word(hmq_pkg::ACT_EXTRACT, 12'd0, 16'd0, 16'd0, 32'd0);
      drain();

      random_mix(300, 40, 25, 20);
      // fill past capacity with inserts only, then an extract-heavy mix
      for (int i = 0; i < 1030; i++) begin
         send_word(hmq_pkg::ACT_INSERT, VTX_BITS'($urandom_range(4095)),
                   16'($urandom), 16'($urandom), pick_key());
      end
      random_mix(300, 15, 60, 15);
      drain();
      repeat (100) @(posedge clock);

      $display("%0d request words sent, %0d successful extracts, %0d inserts into a full heap",
               words_sent, extract_count, full_count);
      if (fail_count == 0) begin
         $display("tb_indexed_min_heap_queue passed");
      end else begin
         $display("tb_indexed_min_heap_queue failed");
      end
      $finish;
   end

endmodule
